FILE: src/u2m_pkg.sv
`default_nettype none
package u2m_pkg;

  localparam int MSG_BYTES   = 8;
  localparam int MSG_CNT_W   = 4;
  localparam int MSG_IDX_W   = 3;
  localparam int SYSEX_MAX   = 6;
  localparam int QUEUE_DEPTH = 2;

  // message type codes (word0 bits 31:28)
  localparam logic [3:0] MT_SYSTEM  = 4'h1;
  localparam logic [3:0] MT_CHANNEL = 4'h2;
  localparam logic [3:0] MT_SYSEX7  = 4'h3;

  // sysex7 packet kind for a complete message
  localparam logic [3:0] SX_COMPLETE = 4'h0;

  localparam logic [7:0] ST_MTC_QF   = 8'hF1;
  localparam logic [7:0] ST_SONG_POS = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL = 8'hF3;
  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_EOX      = 8'hF7;
  localparam logic [7:0] DATA_MASK   = 8'h7F;

  typedef struct packed {
    logic [31:0] ump_word0;
    logic [31:0] ump_word1;
  } in_t;

  typedef struct packed {
    logic [7:0] midi_byte;
    logic       last_byte;
  } out_t;

  // one decoded message: bytes in wire order, byte 0 first, and its length
  typedef struct packed {
    logic [MSG_BYTES-1:0][7:0] bytes;
    logic [MSG_CNT_W-1:0]      count;
  } msg_t;

endpackage
`default_nettype wire

FILE: src/u2m_front.sv
`default_nettype none
module u2m_front import u2m_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      msg_valid,
  input  wire logic msg_ready,
  output msg_t      msg
);

  logic [3:0] mtype;
  logic [3:0] sx_kind;
  logic [3:0] sx_len;
  logic [7:0] status;
  logic [7:0] d1;
  logic [7:0] d2;
  logic [2:0] len_sat;
  logic [5:0][7:0] sx_data;
  msg_t       dec;
  logic       load;
  logic       fv;
  msg_t       fmsg;

  assign mtype   = in_data.ump_word0[31:28];
  assign sx_kind = in_data.ump_word0[23:20];
  assign sx_len  = in_data.ump_word0[19:16];
  assign status  = in_data.ump_word0[23:16];
  assign d1      = in_data.ump_word0[15:8];
  assign d2      = in_data.ump_word0[7:0];
  assign len_sat = (sx_len > 4'(SYSEX_MAX)) ? 3'(SYSEX_MAX) : sx_len[2:0];

  assign sx_data[0] = d1 & DATA_MASK;
  assign sx_data[1] = d2 & DATA_MASK;
  assign sx_data[2] = in_data.ump_word1[31:24] & DATA_MASK;
  assign sx_data[3] = in_data.ump_word1[23:16] & DATA_MASK;
  assign sx_data[4] = in_data.ump_word1[15:8]  & DATA_MASK;
  assign sx_data[5] = in_data.ump_word1[7:0]   & DATA_MASK;

  always_comb begin
    dec.bytes    = '0;
    dec.bytes[0] = status;
    dec.bytes[1] = d1;
    dec.bytes[2] = d2;
    dec.count    = '0;
    case (mtype)
      MT_SYSTEM: begin
        if (status == ST_SONG_POS) begin
          dec.count = MSG_CNT_W'(3);
        end else if (status == ST_MTC_QF || status == ST_SONG_SEL) begin
          dec.count = MSG_CNT_W'(2);
        end else begin
          dec.count = MSG_CNT_W'(1);
        end
      end
      MT_CHANNEL: begin
        if (status[7:6] == 2'b10 || status[7:4] == 4'hE) begin
          dec.count = MSG_CNT_W'(3);
        end else if (status[7:5] == 3'b110) begin
          dec.count = MSG_CNT_W'(2);
        end
      end
      MT_SYSEX7: begin
        if (sx_kind == SX_COMPLETE) begin
          dec.bytes[0] = ST_SYSEX;
          for (int k = 1; k < MSG_BYTES; k++) begin
            if (k - 1 < int'(len_sat)) begin
              dec.bytes[k] = sx_data[k-1];
            end else begin
              dec.bytes[k] = ST_EOX;
            end
          end
          dec.count = MSG_CNT_W'(len_sat) + MSG_CNT_W'(2);
        end
      end
      default: dec.count = '0;
    endcase
  end

  assign in_stall  = fv && !msg_ready;
  assign load      = in_valid && !in_stall;
  assign msg_valid = fv;
  assign msg       = fmsg;

  // packets that decode to nothing are dropped here
  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (load) begin
      fv <= (dec.count != '0);
    end else if (msg_ready) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fmsg <= dec;
    end
  end

endmodule
`default_nettype wire

FILE: src/u2m_queue.sv
`default_nettype none
module u2m_queue import u2m_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  output logic      ready,
  input  wire msg_t wr_msg,
  output logic      valid,
  input  wire logic pop,
  output msg_t      rd_msg
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  msg_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic             do_push;
  logic             do_pop;

  assign ready   = (cnt != CNT_W'(DEPTH));
  assign valid   = (cnt != '0);
  assign do_push = push && ready;
  assign do_pop  = pop && valid;
  assign rd_msg  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_msg;
    end
  end

endmodule
`default_nettype wire

FILE: src/u2m_back.sv
`default_nettype none
module u2m_back import u2m_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic msg_valid,
  output logic      msg_pop,
  input  wire msg_t msg,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  logic                 busy;
  msg_t                 cur;
  logic [MSG_IDX_W-1:0] idx;
  logic                 is_last;
  logic                 beat_done;

  assign is_last   = ({1'b0, idx} == cur.count - MSG_CNT_W'(1));
  assign beat_done = busy && !out_stall;
  // next message loads as the last beat of the current one leaves
  assign msg_pop   = msg_valid && (!busy || (beat_done && is_last));

  assign out_valid          = busy;
  assign out_data.midi_byte = cur.bytes[idx];
  assign out_data.last_byte = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (msg_pop) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (beat_done) begin
      if (is_last) begin
        busy <= 1'b0;
        idx  <= '0;
      end else begin
        idx <= idx + MSG_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (msg_pop) begin
      cur <= msg;
    end
  end

endmodule
`default_nettype wire

FILE: src/ump_to_midi1_decoder.sv
// ump to midi 1.0 byte translator
// input channel: in_valid / in_stall / in_data, one beat is one packet
//   (ump_word0, ump_word1); a beat is taken when in_valid is high and
//   in_stall is low
// output channel: out_valid / out_stall / out_data, one beat is one midi
//   byte, last_byte marks the final byte of a message
// front stage decodes a packet into a byte list and a count;
//   packets that translate to nothing are dropped there
// a small message queue (QDEPTH entries) sits between front and back
// back stage serializes one byte per cycle from its message register while out_stall is low
// path: a taken packet passes the front register and the queue before the
//   back message register loads it and its first byte shows on out_valid
// throughput: one byte per cycle while out_stall is low; a packet of n bytes
//   (1 to 8) holds the serializer for n byte beats, so the byte-wide output
//   port sets the packet rate
// reset: rst clears all valid flags and the queue; nothing is emitted
// output stall: the current byte holds; once queue and front fill, in_stall
//   rises and packets wait upstream
`default_nettype none
module ump_to_midi1_decoder import u2m_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  // front to queue
  logic f_valid;
  logic q_ready;
  msg_t f_msg;

  // queue to back
  logic q_valid;
  logic q_pop;
  msg_t q_msg;

  u2m_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .msg_valid (f_valid),
    .msg_ready (q_ready),
    .msg       (f_msg)
  );

  u2m_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (f_valid),
    .ready  (q_ready),
    .wr_msg (f_msg),
    .valid  (q_valid),
    .pop    (q_pop),
    .rd_msg (q_msg)
  );

  u2m_back u_back (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (q_valid),
    .msg_pop   (q_pop),
    .msg       (q_msg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: sim/tb.sv
`default_nettype none
module tb;
  import u2m_pkg::*;

  // message types and sysex kinds that the block must ignore
  localparam logic [3:0] MT_UTILITY    = 4'h0;
  localparam logic [3:0] MT_M2_CHANNEL = 4'h4;
  localparam logic [3:0] MT_STREAM     = 4'hF;
  localparam logic [3:0] SX_START      = 4'h1;
  localparam logic [3:0] SX_RESERVED   = 4'hF;

  // channel voice status ranges, plus system clock and reset status bytes
  localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
  localparam logic [7:0] ST_CTRL_LAST = 8'hBF;
  localparam logic [7:0] ST_PROGRAM   = 8'hC0;
  localparam logic [7:0] ST_PRESS_END = 8'hDF;
  localparam logic [7:0] ST_BEND      = 8'hE0;
  localparam logic [7:0] ST_BEND_LAST = 8'hEF;
  localparam logic [7:0] ST_NOTE_ON   = 8'h90;
  localparam logic [7:0] ST_CLOCK     = 8'hF8;
  localparam logic [7:0] ST_RESET     = 8'hFF;

  // translates each accepted packet into the byte list the block should emit
  // and checks emitted bytes against it in order
  class midi_byte_board;
    out_t expected_bytes[$];
    int   errors;
    int   packets;
    int   talking_packets;
    int   sysex_packets;
    int   bytes_checked;

    function new();
      errors = 0;
      packets = 0;
      talking_packets = 0;
      sysex_packets = 0;
      bytes_checked = 0;
    endfunction

    function void note_packet(in_t pkt);
      logic [7:0]      msg [8];
      logic [3:0]      mtype;
      logic [7:0]      status;
      logic [5:0][7:0] sx;
      int              len;
      int              n;
      out_t            b;
      mtype  = pkt.ump_word0[31:28];
      status = pkt.ump_word0[23:16];
      sx     = {pkt.ump_word0[15:0], pkt.ump_word1};
      n      = 0;
      msg[0] = status;
      msg[1] = pkt.ump_word0[15:8];
      msg[2] = pkt.ump_word0[7:0];
      case (mtype)
        MT_SYSTEM: begin
          if (status == ST_SONG_POS) n = 3;
          else if (status == ST_MTC_QF || status == ST_SONG_SEL) n = 2;
          else n = 1;
        end
        MT_CHANNEL: begin
          if ((status >= ST_NOTE_OFF && status <= ST_CTRL_LAST) ||
              (status >= ST_BEND && status <= ST_BEND_LAST)) n = 3;
          else if (status >= ST_PROGRAM && status <= ST_PRESS_END) n = 2;
        end
        MT_SYSEX7: begin
          if (pkt.ump_word0[23:20] == SX_COMPLETE) begin
            // length nibble saturates at six data bytes
            len = int'(pkt.ump_word0[19:16]);
            if (len > SYSEX_MAX) len = SYSEX_MAX;
            msg[0] = ST_SYSEX;
            for (int i = 0; i < len; i++) msg[1 + i] = sx[5 - i] & DATA_MASK;
            msg[1 + len] = ST_EOX;
            n = len + 2;
            sysex_packets++;
          end
        end
        default: n = 0;
      endcase
      for (int k = 0; k < n; k++) begin
        b.midi_byte = msg[k];
        b.last_byte = (k == n - 1);
        expected_bytes.push_back(b);
      end
      packets++;
      if (n > 0) talking_packets++;
    endfunction

    function void check_byte(out_t got);
      out_t want;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte, expected none, got %02h last %0b",
                 $time, got.midi_byte, got.last_byte);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      bytes_checked++;
      if (got.midi_byte !== want.midi_byte) begin
        $display("%0t: midi_byte mismatch, expected %02h, got %02h",
                 $time, want.midi_byte, got.midi_byte);
        errors++;
      end
      if (got.last_byte !== want.last_byte) begin
        $display("%0t: last_byte mismatch, expected %0b, got %0b",
                 $time, want.last_byte, got.last_byte);
        errors++;
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // percent chance per cycle of a sender gap and of a receiver stall
  int idle_pct = 0;
  int stall_pct = 0;

  midi_byte_board board;

  ump_to_midi1_decoder DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5000000;
    $display("tb: done, errors");
    $finish;
  end

  // receiver side: random stall, decided at the falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // output beat monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      board.check_byte(out_data);
    end
  end

  // present one packet, with random gaps ahead of it, and hold it until taken
  task automatic send_packet(input in_t pkt);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pkt;
    do @(posedge clk); while (in_stall);
    board.note_packet(pkt);
  endtask

  // stop sending and let every expected byte come out
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // random packet, mostly well-formed messages with random payload bits
  function automatic in_t make_packet();
    logic [31:0] w0;
    logic [31:0] w1;
    int          pick;
    w0   = $urandom;
    w1   = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      // valid channel voice status
      w0[31:28] = MT_CHANNEL;
      w0[23:16] = 8'($urandom_range(ST_NOTE_OFF, ST_BEND_LAST));
    end else if (pick < 52) begin
      // complete sysex, mostly legal lengths, sometimes oversized
      w0[31:28] = MT_SYSEX7;
      w0[23:20] = SX_COMPLETE;
      if ($urandom_range(0, 4) != 0) w0[19:16] = 4'($urandom_range(0, SYSEX_MAX));
    end else if (pick < 67) begin
      // system messages, weighted toward the ones with data
      w0[31:28] = MT_SYSTEM;
      case ($urandom_range(0, 3))
        0: w0[23:16] = ST_SONG_POS;
        1: w0[23:16] = ST_MTC_QF;
        2: w0[23:16] = ST_SONG_SEL;
        default: ;
      endcase
    end else if (pick < 77) begin
      // channel type with any status, some invalid
      w0[31:28] = MT_CHANNEL;
    end else if (pick < 87) begin
      // sysex fragments other than complete
      w0[31:28] = MT_SYSEX7;
      if (w0[23:20] == SX_COMPLETE) w0[23:20] = SX_START;
    end
    // remainder: raw noise of any type
    return {w0, w1};
  endfunction

  // run random packets until enough of them produced output
  task automatic random_phase(input int talking);
    int target;
    target = board.talking_packets + talking;
    while (board.talking_packets < target) send_packet(make_packet());
  endtask

  initial begin
    board = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: every status class, length extremes, masking, ignored types
    send_packet({MT_SYSTEM, 4'h0, ST_SONG_POS, 16'hFF80, 32'h0});
    send_packet({MT_SYSTEM, 4'h5, ST_MTC_QF, 16'h81FF, 32'h0});
    send_packet({MT_SYSTEM, 4'hA, ST_SONG_SEL, 16'h7F00, 32'h0});
    send_packet({MT_SYSTEM, 4'hF, ST_CLOCK, 16'hFFFF, 32'hFFFFFFFF});
    send_packet({MT_SYSTEM, 4'h0, 8'h00, 16'h1234, 32'h0});
    send_packet({MT_CHANNEL, 4'h3, ST_NOTE_OFF, 16'h00FF, 32'hFFFFFFFF});
    send_packet({MT_CHANNEL, 4'h0, ST_CTRL_LAST, 16'hFF00, 32'h0});
    send_packet({MT_CHANNEL, 4'h7, ST_PROGRAM, 16'hFFFF, 32'h0});
    send_packet({MT_CHANNEL, 4'h0, ST_PRESS_END, 16'h8001, 32'h0});
    send_packet({MT_CHANNEL, 4'hC, ST_BEND, 16'h0000, 32'h0});
    send_packet({MT_CHANNEL, 4'h0, ST_BEND_LAST, 16'hFFFF, 32'h0});
    send_packet({MT_CHANNEL, 4'hF, ST_NOTE_ON, 16'hFFFF, 32'hFFFFFFFF});
    send_packet({MT_CHANNEL, 4'h0, 8'h7F, 16'h4040, 32'h0});
    send_packet({MT_CHANNEL, 4'h0, ST_SYSEX, 16'h4040, 32'h0});
    send_packet({MT_CHANNEL, 4'h0, ST_RESET, 16'h4040, 32'h0});
    send_packet({MT_SYSEX7, 4'h0, SX_COMPLETE, 4'd0, 16'hFFFF, 32'hFFFFFFFF});
    send_packet({MT_SYSEX7, 4'h2, SX_COMPLETE, 4'd1, 16'h8081, 32'h0});
    send_packet({MT_SYSEX7, 4'h0, SX_COMPLETE, 4'd6, 16'hFFFF, 32'hFFFFFFFF});
    send_packet({MT_SYSEX7, 4'h0, SX_COMPLETE, 4'd7, 16'h0102, 32'h03040506});
    send_packet({MT_SYSEX7, 4'hF, SX_COMPLETE, 4'hF, 16'hFFFF, 32'hFFFFFFFF});
    send_packet({MT_SYSEX7, 4'h0, SX_START, 4'd6, 16'h1111, 32'h22222222});
    send_packet({MT_SYSEX7, 4'h0, SX_RESERVED, 4'd3, 16'h1111, 32'h22222222});
    send_packet({MT_UTILITY, 4'h0, ST_SONG_POS, 16'hFFFF, 32'h0});
    send_packet({MT_M2_CHANNEL, 4'h0, ST_NOTE_ON, 16'h4040, 32'hFFFFFFFF});
    send_packet({MT_STREAM, 28'hFFFFFFF, 32'hFFFFFFFF});
    drain();

    // random phases: free flow, sender gaps, receiver stalls, both light
    idle_pct = 0;  stall_pct = 0;
    random_phase(32);
    drain();
    idle_pct = 67; stall_pct = 0;
    random_phase(32);
    drain();
    idle_pct = 0;  stall_pct = 67;
    random_phase(32);
    drain();
    idle_pct = 17; stall_pct = 17;
    random_phase(32);
    drain();

    // let any stray byte surface, with receiver stalls off
    stall_pct = 0;
    repeat (12) @(posedge clk);

    $display("tb: %0d packets sent, %0d produced bytes, %0d complete sysex",
             board.packets, board.talking_packets, board.sysex_packets);
    $display("tb: %0d bytes checked under four flow-control mixes",
             board.bytes_checked);
    if (board.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
src/u2m_pkg.sv
src/u2m_front.sv
src/u2m_queue.sv
src/u2m_back.sv
src/ump_to_midi1_decoder.sv
sim/tb.sv
